/* hw/rtl/packet_image_loader_macros.svh */
// ---------------------------------------------------------------------------
// packet_image_loader assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_IMAGE_LOADER_MACROS_SVH
`define PACKET_IMAGE_LOADER_MACROS_SVH

// cond must hold at every edge out of reset
`define PIL_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define PIL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pil_pkg.sv */
// ---------------------------------------------------------------------------
// pil_pkg
// Types and constants shared by the packet image loader modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pil_pkg;

  localparam int unsigned PIL_ADDR_WIDTH = 32;
  localparam int unsigned HDR_BYTES      = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MAGIC = 2'd2;

  // reset values
  localparam logic [31:0] LOAD_BASE_RST   = 32'h0010_0000;
  localparam logic [15:0] SERVER_PORT_RST = 16'd1235;
  localparam logic [31:0] IMAGE_MAGIC_RST = 32'hDEAD_BEEF;

  typedef struct packed {
    logic [31:0] load_base;
    logic [15:0] server_port;
    logic [31:0] image_magic;
  } cfg_t;

  typedef struct packed {
    logic [15:0] source_port;
    logic        end_of_packet;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic checksum_error;
    logic load_done;
    logic send_ack;
  } pil_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/packet_image_loader.sv */
// ---------------------------------------------------------------------------
// packet_image_loader
// Boot image loader fed with UDP payload bytes; emits memory writes,
// ACK requests and the final load verdict.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata payload_byte, tuser source_port,
//           |     |                         | tlast end_of_packet
//  m_axis   | out | m_axis_tvalid/tready    | tdata result item (see port comment)
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i register, cfg_data_i value
//
// One item per cycle while m_axis_tready stays high; each result passes through
// the input register, then the result register. pil_core updates its state once
// per accepted item, which sets that rate.
// Reset clears all loader state and loads the default registers; no sweep.
// With m_axis_tready low the result holds and one more item is still taken
// into the input register before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module packet_image_loader import pil_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = PIL_ADDR_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // payload_byte
  input  wire logic [15:0]                  s_axis_tuser,  // source_port
  input  wire logic                         s_axis_tlast,  // end_of_packet
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // mem_write, mem_address, mem_data, send_ack, load_done, checksum_error,
  // start_address, zero fill
  output logic [((ADDR_WIDTH+44+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  localparam int unsigned RES_W = ADDR_WIDTH + 44;
  localparam int unsigned OUT_W = ((ADDR_WIDTH + 44 + 7) / 8) * 8;

  cfg_t                  cfg;
  in_item_t              in_item, core_item;
  logic                  item_valid;
  logic                  res_ready;
  logic                  fire;
  logic                  mem_write;
  logic [ADDR_WIDTH-1:0] mem_address;
  logic [7:0]            mem_data;
  pil_flags_t            flags;
  logic [31:0]           start_address;
  logic [OUT_W-1:0]      res_bits;

  pil_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.source_port   = s_axis_tuser;
  assign in_item.end_of_packet = s_axis_tlast;
  assign in_item.payload_byte  = s_axis_tdata;

  pil_stage #(.W($bits(in_item_t))) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_item),
    .valid_o (item_valid),
    .ready_i (res_ready),
    .data_o  (core_item)
  );

  assign fire = item_valid && res_ready;

  pil_core #(.ADDR_WIDTH(ADDR_WIDTH)) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .item_i          (core_item),
    .cfg_i           (cfg),
    .mem_write_o     (mem_write),
    .mem_address_o   (mem_address),
    .mem_data_o      (mem_data),
    .flags_o         (flags),
    .start_address_o (start_address)
  );

  assign res_bits = OUT_W'(RES_W'({start_address, flags.checksum_error, flags.load_done,
                                   flags.send_ack, mem_data, mem_address, mem_write}));

  pil_stage #(.W(OUT_W)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .ready_o (res_ready),
    .data_i  (res_bits),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/pil_cfg.sv */
// ---------------------------------------------------------------------------
// pil_cfg
// Configuration register file; writes accepted every cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pil_cfg import pil_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOAD_BASE:   cfg_d.load_base   = cfg_data_i;
        REG_SERVER_PORT: cfg_d.server_port = cfg_data_i[15:0];
        REG_IMAGE_MAGIC: cfg_d.image_magic = cfg_data_i;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_base   <= LOAD_BASE_RST;
      cfg_q.server_port <= SERVER_PORT_RST;
      cfg_q.image_magic <= IMAGE_MAGIC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/pil_stage.sv */
// ---------------------------------------------------------------------------
// pil_stage
// One register slice with valid/ready; takes a new item while draining.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pil_stage #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [W-1:0] data_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [W-1:0]      data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/pil_core.sv */
// ---------------------------------------------------------------------------
// pil_core
// Loader state: header capture, image write address, running sum, verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "packet_image_loader_macros.svh"

module pil_core import pil_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = PIL_ADDR_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire in_item_t              item_i,
  input  wire cfg_t                  cfg_i,
  output logic                       mem_write_o,
  output logic [ADDR_WIDTH-1:0]      mem_address_o,
  output logic [7:0]                 mem_data_o,
  output pil_flags_t                 flags_o,
  output logic [31:0]                start_address_o
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [4:0] HDR_FULL = 5'(HDR_BYTES);

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  header_index_q, header_index_d;
  logic [31:0] header_magic_q, header_magic_d;
  logic [31:0] image_size_q, image_size_d;
  logic [31:0] entry_word_q, entry_word_d;
  logic [31:0] expected_sum_q, expected_sum_d;
  logic [31:0] data_offset_q, data_offset_d;
  logic [31:0] running_sum_q, running_sum_d;
  logic        port_match;

  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                           logic [7:0] b);
    logic [31:0] r;
    r = word;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

  assign port_match = item_i.source_port == cfg_i.server_port;

  always_comb begin
    phase_d        = phase_q;
    header_index_d = header_index_q;
    header_magic_d = header_magic_q;
    image_size_d   = image_size_q;
    entry_word_d   = entry_word_q;
    expected_sum_d = expected_sum_q;
    data_offset_d  = data_offset_q;
    running_sum_d  = running_sum_q;

    mem_write_o     = 1'b0;
    mem_address_o   = '0;
    mem_data_o      = '0;
    flags_o         = '0;
    start_address_o = '0;

    unique case (phase_q)
      PH_SEARCH: begin
        if (port_match) begin
          if (!header_index_q[4]) begin
            mem_write_o   = 1'b1;
            mem_address_o = ADDR_WIDTH'(cfg_i.load_base) + ADDR_WIDTH'(header_index_q);
            mem_data_o    = item_i.payload_byte;
            unique case (header_index_q[3:2])
              2'd0: header_magic_d = put_byte(header_magic_q, header_index_q[1:0],
                                              item_i.payload_byte);
              2'd1: image_size_d   = put_byte(image_size_q, header_index_q[1:0],
                                              item_i.payload_byte);
              2'd2: entry_word_d   = put_byte(entry_word_q, header_index_q[1:0],
                                              item_i.payload_byte);
              default: expected_sum_d = put_byte(expected_sum_q, header_index_q[1:0],
                                                 item_i.payload_byte);
            endcase
            header_index_d = header_index_q + 5'd1;
          end
          if (item_i.end_of_packet) begin
            if (header_index_d == HDR_FULL && header_magic_d == cfg_i.image_magic) begin
              flags_o.send_ack = 1'b1;
              phase_d          = PH_DATA;
              data_offset_d    = '0;
              running_sum_d    = '0;
            end else begin
              // short header or bad magic: search again
              phase_d        = PH_SEARCH;
              header_index_d = '0;
              header_magic_d = '0;
              image_size_d   = '0;
              entry_word_d   = '0;
              expected_sum_d = '0;
              data_offset_d  = '0;
              running_sum_d  = '0;
            end
          end
        end
      end
      PH_DATA: begin
        if (port_match) begin
          mem_write_o   = 1'b1;
          mem_address_o = ADDR_WIDTH'(cfg_i.load_base) + ADDR_WIDTH'(HDR_BYTES)
                        + ADDR_WIDTH'(data_offset_q);
          mem_data_o    = item_i.payload_byte;
          if (data_offset_q < image_size_q) begin
            running_sum_d = running_sum_q + 32'(item_i.payload_byte);
          end
          if (data_offset_q != '1) begin
            data_offset_d = data_offset_q + 32'd1;  // saturates at all ones
          end
          if (item_i.end_of_packet) begin
            flags_o.send_ack = 1'b1;
            if (data_offset_d >= image_size_q) begin
              if (running_sum_d == expected_sum_q) begin
                flags_o.load_done = 1'b1;
                start_address_o   = entry_word_q;
                phase_d           = PH_DONE;
              end else begin
                flags_o.checksum_error = 1'b1;
                phase_d        = PH_SEARCH;
                header_index_d = '0;
                header_magic_d = '0;
                image_size_d   = '0;
                entry_word_d   = '0;
                expected_sum_d = '0;
                data_offset_d  = '0;
                running_sum_d  = '0;
              end
            end
          end
        end
      end
      default: ;  // done: everything ignored until reset
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SEARCH;
      header_index_q <= '0;
      header_magic_q <= '0;
      image_size_q   <= '0;
      entry_word_q   <= '0;
      expected_sum_q <= '0;
      data_offset_q  <= '0;
      running_sum_q  <= '0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      header_index_q <= header_index_d;
      header_magic_q <= header_magic_d;
      image_size_q   <= image_size_d;
      entry_word_q   <= entry_word_d;
      expected_sum_q <= expected_sum_d;
      data_offset_q  <= data_offset_d;
      running_sum_q  <= running_sum_d;
    end
  end

  `PIL_ASSERT(a_hdr_idx_range, header_index_q <= HDR_FULL, "header index past header")
  `PIL_ASSERT_IMPL(a_data_hdr_full, phase_q == PH_DATA, header_index_q == HDR_FULL,
                   "data phase without full header")
  `PIL_ASSERT_IMPL(a_verdict_excl, fire_i,
                   !(flags_o.load_done && flags_o.checksum_error), "done and error together")
  `PIL_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE || (fire_i && flags_o.load_done),
                   phase_q == PH_DONE, "left done phase")

endmodule

`default_nettype wire
